// ===== src/xoro_pkg.sv =====
// shared types, opcodes and constants of the xoroshiro128+ generator
package xoro_pkg;

  localparam int WordW = 64;
  localparam int FracW = 53;
  localparam int SeedW = 32;
  localparam int JumpIdxW = 7;

  localparam logic [1:0] OP_SEED = 2'd0;
  localparam logic [1:0] OP_NEXT = 2'd1;
  localparam logic [1:0] OP_JUMP = 2'd2;

  localparam logic [WordW-1:0] GOLDEN_INC = 64'h9e3779b97f4a7c15;
  localparam logic [WordW-1:0] MIX_MUL_A  = 64'hbf58476d1ce4e5b9;
  localparam logic [WordW-1:0] MIX_MUL_B  = 64'h94d049bb133111eb;

  // word 0 in the low half, scanned from bit 0 upward
  localparam logic [2*WordW-1:0] JUMP_POLY = {64'hd86b048b86aa9922, 64'hbeac0467eba5facb};

  localparam int ROT_A = 55;
  localparam int SHL_B = 14;
  localparam int ROT_C = 36;
  localparam int MIX_SH0 = 30;
  localparam int MIX_SH1 = 27;
  localparam int MIX_SH2 = 31;
  localparam int FRAC_LSB = 11;

  // which partial product of the 64x64 multiply is taken this cycle
  typedef enum logic [1:0] {
    MP_LL = 2'd0,
    MP_LH = 2'd1,
    MP_HL = 2'd2
  } mul_phase_t;

  typedef struct packed {
    logic               ctr_load;
    logic               ctr_inc;
    logic               x_from_ctr;
    logic               x_from_prod;
    logic               mul_en;
    mul_phase_t         mul_phase;
    logic               mul_const_b;
    logic               store_low;
    logic               store_high;
    logic               advance;
    logic               emit;
    logic               jump_clr;
    logic               jump_step;
    logic [JumpIdxW-1:0] jump_bit;
    logic               jump_commit;
  } dp_cmd_t;

  function automatic logic [WordW-1:0] rotl(input logic [WordW-1:0] v, input int amt);
    rotl = (v << amt) | (v >> (WordW - amt));
  endfunction

endpackage

// ===== src/xoro_datapath.sv =====
// state words, splitmix64 seeding datapath, jump accumulator and result register
module xoro_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  xoro_pkg::dp_cmd_t             cmd,
  input  logic [xoro_pkg::SeedW-1:0]    seed_value,
  output logic [xoro_pkg::FracW-1:0]    random_fraction,
  output logic                          result_valid
);

  logic [xoro_pkg::WordW-1:0] s_low, s_high;
  logic [xoro_pkg::WordW-1:0] acc_low, acc_high;
  logic [xoro_pkg::WordW-1:0] ctr, x, prod;

  logic [xoro_pkg::WordW-1:0] sum, hx, low_next, high_next, mix_out, mul_const;
  logic [31:0]                mul_a, mul_b;
  logic [63:0]                mul_p;
  logic [xoro_pkg::WordW-1:0] prod_next;

  always_comb begin
    sum       = s_low + s_high;
    hx        = s_high ^ s_low;
    low_next  = xoro_pkg::rotl(s_low, xoro_pkg::ROT_A) ^ hx ^ (hx << xoro_pkg::SHL_B);
    high_next = xoro_pkg::rotl(hx, xoro_pkg::ROT_C);
    mix_out   = prod ^ (prod >> xoro_pkg::MIX_SH2);
    mul_const = cmd.mul_const_b ? xoro_pkg::MIX_MUL_B : xoro_pkg::MIX_MUL_A;
  end

  // 64x64 product mod 2^64 from three 32x32 partial products
  always_comb begin
    unique case (cmd.mul_phase)
      xoro_pkg::MP_LL: begin
        mul_a = x[31:0];
        mul_b = mul_const[31:0];
      end
      xoro_pkg::MP_LH: begin
        mul_a = x[31:0];
        mul_b = mul_const[63:32];
      end
      xoro_pkg::MP_HL: begin
        mul_a = x[63:32];
        mul_b = mul_const[31:0];
      end
      default: begin
        mul_a = 32'd0;
        mul_b = 32'd0;
      end
    endcase
    mul_p = 64'(mul_a) * 64'(mul_b);
    if (cmd.mul_phase == xoro_pkg::MP_LL) begin
      prod_next = mul_p;
    end else begin
      prod_next = prod + {mul_p[31:0], 32'd0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_low        <= '0;
      s_high       <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.emit;
      if (cmd.advance) begin
        s_low  <= low_next;
        s_high <= high_next;
      end else if (cmd.jump_commit) begin
        s_low  <= acc_low;
        s_high <= acc_high;
      end else begin
        if (cmd.store_low) s_low <= mix_out;
        if (cmd.store_high) s_high <= mix_out;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) random_fraction <= sum[xoro_pkg::WordW-1:xoro_pkg::FRAC_LSB];
    if (cmd.ctr_load) begin
      ctr <= {{(xoro_pkg::WordW-xoro_pkg::SeedW){1'b0}}, seed_value} + xoro_pkg::GOLDEN_INC;
    end else if (cmd.ctr_inc) begin
      ctr <= ctr + xoro_pkg::GOLDEN_INC;
    end
    if (cmd.x_from_ctr) begin
      x <= ctr ^ (ctr >> xoro_pkg::MIX_SH0);
    end else if (cmd.x_from_prod) begin
      x <= prod ^ (prod >> xoro_pkg::MIX_SH1);
    end
    if (cmd.mul_en) prod <= prod_next;
    if (cmd.jump_clr) begin
      acc_low  <= '0;
      acc_high <= '0;
    end else if (cmd.jump_step && xoro_pkg::JUMP_POLY[cmd.jump_bit]) begin
      acc_low  <= acc_low ^ s_low;
      acc_high <= acc_high ^ s_high;
    end
  end

endmodule

// ===== src/xoro_ctrl.sv =====
// controller state machine: opcode decode and sequencing of seed and jump
module xoro_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [1:0]        opcode,
  output logic              busy,
  output xoro_pkg::dp_cmd_t cmd
);

  typedef enum logic [11:0] {
    ST_IDLE    = 12'b000000000001,
    ST_PRE     = 12'b000000000010,
    ST_MA0     = 12'b000000000100,
    ST_MA1     = 12'b000000001000,
    ST_MA2     = 12'b000000010000,
    ST_MID     = 12'b000000100000,
    ST_MB0     = 12'b000001000000,
    ST_MB1     = 12'b000010000000,
    ST_MB2     = 12'b000100000000,
    ST_STORE   = 12'b001000000000,
    ST_JUMP    = 12'b010000000000,
    ST_JCOMMIT = 12'b100000000000
  } state_t;

  state_t                        state, state_next;
  logic                          word_hi, word_hi_next;
  logic [xoro_pkg::JumpIdxW-1:0] cnt, cnt_next;

  assign busy = (state != ST_IDLE);

  always_comb begin
    state_next   = state;
    word_hi_next = word_hi;
    cnt_next     = cnt;
    cmd          = '0;
    cmd.jump_bit = cnt;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          priority if (opcode == xoro_pkg::OP_SEED) begin
            cmd.ctr_load = 1'b1;
            word_hi_next = 1'b0;
            state_next   = ST_PRE;
          end else if (opcode == xoro_pkg::OP_NEXT) begin
            cmd.advance = 1'b1;
            cmd.emit    = 1'b1;
          end else if (opcode == xoro_pkg::OP_JUMP) begin
            cmd.jump_clr = 1'b1;
            cnt_next     = '0;
            state_next   = ST_JUMP;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_PRE: begin
        cmd.x_from_ctr = 1'b1;
        state_next     = ST_MA0;
      end
      ST_MA0: begin
        cmd.mul_en    = 1'b1;
        cmd.mul_phase = xoro_pkg::MP_LL;
        state_next    = ST_MA1;
      end
      ST_MA1: begin
        cmd.mul_en    = 1'b1;
        cmd.mul_phase = xoro_pkg::MP_LH;
        state_next    = ST_MA2;
      end
      ST_MA2: begin
        cmd.mul_en    = 1'b1;
        cmd.mul_phase = xoro_pkg::MP_HL;
        state_next    = ST_MID;
      end
      ST_MID: begin
        cmd.x_from_prod = 1'b1;
        state_next      = ST_MB0;
      end
      ST_MB0: begin
        cmd.mul_en      = 1'b1;
        cmd.mul_const_b = 1'b1;
        cmd.mul_phase   = xoro_pkg::MP_LL;
        state_next      = ST_MB1;
      end
      ST_MB1: begin
        cmd.mul_en      = 1'b1;
        cmd.mul_const_b = 1'b1;
        cmd.mul_phase   = xoro_pkg::MP_LH;
        state_next      = ST_MB2;
      end
      ST_MB2: begin
        cmd.mul_en      = 1'b1;
        cmd.mul_const_b = 1'b1;
        cmd.mul_phase   = xoro_pkg::MP_HL;
        state_next      = ST_STORE;
      end
      ST_STORE: begin
        if (word_hi) begin
          cmd.store_high = 1'b1;
          state_next     = ST_IDLE;
        end else begin
          // first splitmix output done, bump the counter for the second
          cmd.store_low = 1'b1;
          cmd.ctr_inc   = 1'b1;
          word_hi_next  = 1'b1;
          state_next    = ST_PRE;
        end
      end
      ST_JUMP: begin
        cmd.jump_step = 1'b1;
        cmd.advance   = 1'b1;
        cnt_next      = cnt + 1'b1;
        if (cnt == {xoro_pkg::JumpIdxW{1'b1}}) state_next = ST_JCOMMIT;
      end
      ST_JCOMMIT: begin
        cmd.jump_commit = 1'b1;
        state_next      = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      word_hi <= 1'b0;
      cnt     <= '0;
    end else begin
      state   <= state_next;
      word_hi <= word_hi_next;
      cnt     <= cnt_next;
    end
  end

endmodule

// ===== src/xoroshiro128plus_generator.sv =====
// top level of the xoroshiro128+ generator with splitmix64 seeding
//
// A command beat is taken at a rising edge with start high and busy low;
// opcode selects seed, next or jump, seed_value is used by seed only.
// next: the 53-bit fraction (bits 63..11 of the state sum) appears on
//   random_fraction with result_valid high for one cycle, in the cycle after
//   the beat; busy stays low, so a next beat can be taken every cycle.
// seed: two splitmix64 rounds, each on one shared 32x32 multiplier taking
//   three partial products per 64-bit multiply; busy stays high until both state words are stored.
// jump: 128 generator steps with xor accumulation, one step a cycle, then
//   a commit of the accumulated words; busy stays high through the commit.
// opcode 3 is ignored and leaves busy low.
// Seed and jump give no result beat.
// Synchronous reset clears both state words, so next returns zero until a
// seed is done. Results are never held: the receiver must take each beat
// in its cycle.
module xoroshiro128plus_generator (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 opcode,
  input  logic [xoro_pkg::SeedW-1:0] seed_value,
  output logic                       result_valid,
  output logic [xoro_pkg::FracW-1:0] random_fraction
);

  xoro_pkg::dp_cmd_t cmd;

  xoro_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .opcode (opcode),
    .busy   (busy),
    .cmd    (cmd)
  );

  xoro_datapath u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .seed_value      (seed_value),
    .random_fraction (random_fraction),
    .result_valid    (result_valid)
  );

endmodule
